### rtl/core/sensor_frame_receiver_unit_defines.svh
// -----------------------------------------------------------------------------
// Sensor frame receiver: assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// -----------------------------------------------------------------------------
`ifndef SENSOR_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define SENSOR_FRAME_RECEIVER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// checked only outside reset
`define SFR_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("sensor frame receiver assertion failed");

// checked at every edge, reset included
`define SFR_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("sensor frame receiver assertion failed");

`else

`define SFR_ASSERT(lbl, clk, rst, prop)
`define SFR_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

### rtl/core/sfr_pkg.sv
// -----------------------------------------------------------------------------
// Sensor frame receiver package
// Frame layout constants, register indexes and the result record.
// -----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

   localparam int FRAME_BYTES = 24;
   localparam int CHECK_POS   = 22;   // checksum byte position
   localparam int COUNT_W     = $clog2(FRAME_BYTES);

   localparam logic [COUNT_W-1:0] COUNT_HUNT  = '0;
   localparam logic [COUNT_W-1:0] COUNT_FIRST = COUNT_W'(1);
   localparam logic [COUNT_W-1:0] CHECK_INDEX = COUNT_W'(CHECK_POS);
   localparam logic [COUNT_W-1:0] LAST_INDEX  = COUNT_W'(FRAME_BYTES - 1);

   localparam logic [7:0] HEADER_RESET = 8'd123;
   localparam logic [7:0] TAIL_RESET   = 8'd125;

   localparam int CSR_INDEX_W = 8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_HEADER_VALUE = 8'd0,
      CSR_TAIL_VALUE   = 8'd1
   } csr_index_type;

   typedef struct packed {
      logic        [7:0]  stop_flag;
      logic signed [15:0] vel_x;
      logic signed [15:0] vel_y;
      logic signed [15:0] yaw_rate;
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
      logic signed [15:0] gyro_x;
      logic signed [15:0] gyro_y;
      logic signed [15:0] gyro_z;
      logic signed [15:0] supply_mv;
   } sfr_result_type;

endpackage

`default_nettype wire

### rtl/core/sfr_ifs.sv
// -----------------------------------------------------------------------------
// Sensor frame receiver channel interfaces
// Byte request, frame result and register write channels.
// -----------------------------------------------------------------------------
`default_nettype none

interface sfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfr_rsp_if;
   logic               valid;
   logic               ready;
   logic        [7:0]  stop_flag;
   logic signed [15:0] vel_x;
   logic signed [15:0] vel_y;
   logic signed [15:0] yaw_rate;
   logic signed [15:0] accel_x;
   logic signed [15:0] accel_y;
   logic signed [15:0] accel_z;
   logic signed [15:0] gyro_x;
   logic signed [15:0] gyro_y;
   logic signed [15:0] gyro_z;
   logic signed [15:0] supply_mv;

   modport source (output valid, output stop_flag, output vel_x, output vel_y,
                   output yaw_rate, output accel_x, output accel_y, output accel_z,
                   output gyro_x, output gyro_y, output gyro_z, output supply_mv,
                   input ready);
   modport sink   (input valid, input stop_flag, input vel_x, input vel_y,
                   input yaw_rate, input accel_x, input accel_y, input accel_z,
                   input gyro_x, input gyro_y, input gyro_z, input supply_mv,
                   output ready);
endinterface

interface sfr_csr_if;
   logic                                valid;
   logic                                ready;
   logic [sfr_pkg::CSR_INDEX_W-1:0]     index;
   logic [7:0]                          data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/sensor_frame_receiver_unit.sv
// -----------------------------------------------------------------------------
// Sensor frame receiver unit
// Byte-serial frame parser: header hunt, 24-byte frame, tail and XOR check.
//
//   channel   dir   carries
//   req_if    in    one received byte (rx_byte)
//   rsp_if    out   stop flag and ten signed 16-bit words of a good frame
//   csr_if    in    register writes: 0 header value, 1 tail value
//
// One byte per cycle, except while the last byte of a frame waits; each byte
// is registered in the input register, and a frame result is loaded into the
// result register at the edge its last byte leaves the input register.
// Synchronous reset: hunting for a header, header 123, tail 125.
// Only the last byte of a frame waits, and only while the result register
// is full and rsp_if.ready is low.
// Register writes are always ready.
// -----------------------------------------------------------------------------
`default_nettype none

module sensor_frame_receiver_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   sfr_req_if.sink    req_if,
   sfr_rsp_if.source  rsp_if,
   sfr_csr_if.sink    csr_if
);

   logic [7:0]              header_ff;
   logic [7:0]              tail_ff;
   logic                    byte_valid;
   logic [7:0]              byte_data;
   logic                    advance;
   logic                    out_space;
   logic                    res_valid;
   sfr_pkg::sfr_result_type res;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= sfr_pkg::HEADER_RESET;
         tail_ff   <= sfr_pkg::TAIL_RESET;
      end else if (csr_if.valid) begin
         if (csr_if.index == sfr_pkg::CSR_HEADER_VALUE) begin
            header_ff <= csr_if.data;
         end
         if (csr_if.index == sfr_pkg::CSR_TAIL_VALUE) begin
            tail_ff <= csr_if.data;
         end
      end
   end

   sfr_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .advance    (advance),
      .byte_valid (byte_valid),
      .byte_data  (byte_data)
   );

   sfr_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (byte_valid),
      .in_byte      (byte_data),
      .in_advance   (advance),
      .header_value (header_ff),
      .tail_value   (tail_ff),
      .out_space    (out_space),
      .res_valid    (res_valid),
      .res          (res)
   );

   sfr_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load_valid (res_valid),
      .load_data  (res),
      .space      (out_space),
      .rsp_if     (rsp_if)
   );

endmodule

`default_nettype wire

### rtl/core/sfr_in_reg.sv
// -----------------------------------------------------------------------------
// Sensor frame receiver input register
// Registers one received byte; refills in the cycle the parser consumes it.
// -----------------------------------------------------------------------------
`default_nettype none

module sfr_in_reg (
   input  wire logic       clock,
   input  wire logic       reset,
   sfr_req_if.sink         req_if,
   input  wire logic       advance,
   output logic            byte_valid,
   output logic [7:0]      byte_data
);

   logic       valid_ff, valid_in;
   logic [7:0] data_ff;

   assign req_if.ready = !valid_ff || advance;
   assign valid_in     = req_if.valid || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         data_ff <= req_if.rx_byte;
      end
   end

   assign byte_valid = valid_ff;
   assign byte_data  = data_ff;

endmodule

`default_nettype wire

### rtl/core/sfr_parser.sv
// -----------------------------------------------------------------------------
// Sensor frame receiver parser
// Header hunt, byte count, running XOR and frame byte store; frame check.
// -----------------------------------------------------------------------------
`default_nettype none
`include "sensor_frame_receiver_unit_defines.svh"

module sfr_parser (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   input  wire logic [7:0]            in_byte,
   output logic                       in_advance,
   input  wire logic [7:0]            header_value,
   input  wire logic [7:0]            tail_value,
   input  wire logic                  out_space,
   output logic                       res_valid,
   output sfr_pkg::sfr_result_type    res
);

   logic [sfr_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [7:0]                  parity_ff, parity_in;
   logic [7:0]                  store_ff [1:sfr_pkg::CHECK_POS];
   logic                        take;
   logic                        at_last;

   assign at_last    = (count_ff == sfr_pkg::LAST_INDEX);
   // the last byte can only be taken if the result register has room
   assign in_advance = !at_last || out_space;
   assign take       = in_valid && in_advance;

   always_comb begin
      count_in  = count_ff;
      parity_in = parity_ff;
      if (take) begin
         priority if (count_ff == sfr_pkg::COUNT_HUNT) begin
            if (in_byte == header_value) begin
               count_in  = sfr_pkg::COUNT_FIRST;
               parity_in = in_byte;
            end
         end else if (count_ff >= sfr_pkg::LAST_INDEX) begin
            count_in = sfr_pkg::COUNT_HUNT;
         end else begin
            count_in = count_ff + sfr_pkg::COUNT_FIRST;
            if (count_ff < sfr_pkg::CHECK_INDEX) begin
               parity_in = parity_ff ^ in_byte;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= sfr_pkg::COUNT_HUNT;
         parity_ff <= '0;
      end else begin
         count_ff  <= count_in;
         parity_ff <= parity_in;
      end
   end

   // byte 0 is the header and byte 23 arrives live, so only 1..22 are held
   for (genvar i = 1; i <= sfr_pkg::CHECK_POS; i++) begin : g_store
      always_ff @(posedge clock) begin
         if (take && count_ff == sfr_pkg::COUNT_W'(i)) begin
            store_ff[i] <= in_byte;
         end
      end
   end

   assign res_valid = take && at_last && (in_byte == tail_value) &&
                      (parity_ff == store_ff[sfr_pkg::CHECK_POS]);

   always_comb begin
      res.stop_flag = store_ff[1];
      res.vel_x     = $signed({store_ff[2],  store_ff[3]});
      res.vel_y     = $signed({store_ff[4],  store_ff[5]});
      res.yaw_rate  = $signed({store_ff[6],  store_ff[7]});
      res.accel_x   = $signed({store_ff[8],  store_ff[9]});
      res.accel_y   = $signed({store_ff[10], store_ff[11]});
      res.accel_z   = $signed({store_ff[12], store_ff[13]});
      res.gyro_x    = $signed({store_ff[14], store_ff[15]});
      res.gyro_y    = $signed({store_ff[16], store_ff[17]});
      res.gyro_z    = $signed({store_ff[18], store_ff[19]});
      res.supply_mv = $signed({store_ff[20], store_ff[21]});
   end

   `SFR_ASSERT_ALWAYS(a_hunt_after_reset, clock, $past(reset) |-> count_ff == sfr_pkg::COUNT_HUNT)
   `SFR_ASSERT(a_count_in_range, clock, reset, count_ff <= sfr_pkg::LAST_INDEX)
   `SFR_ASSERT(a_last_byte_rehunts, clock, reset, (take && at_last) |=> count_ff == sfr_pkg::COUNT_HUNT)
   `SFR_ASSERT(a_result_has_room, clock, reset, res_valid |-> out_space)

endmodule

`default_nettype wire

### rtl/core/sfr_out_reg.sv
// -----------------------------------------------------------------------------
// Sensor frame receiver result register
// Holds one checked frame until the result channel takes it.
// -----------------------------------------------------------------------------
`default_nettype none

module sfr_out_reg (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     load_valid,
   input  wire sfr_pkg::sfr_result_type  load_data,
   output logic                          space,
   sfr_rsp_if.source                     rsp_if
);

   logic                    valid_ff;
   sfr_pkg::sfr_result_type data_ff;

   assign space = !valid_ff || rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (space) begin
         valid_ff <= load_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (space && load_valid) begin
         data_ff <= load_data;
      end
   end

   assign rsp_if.valid     = valid_ff;
   assign rsp_if.stop_flag = data_ff.stop_flag;
   assign rsp_if.vel_x     = data_ff.vel_x;
   assign rsp_if.vel_y     = data_ff.vel_y;
   assign rsp_if.yaw_rate  = data_ff.yaw_rate;
   assign rsp_if.accel_x   = data_ff.accel_x;
   assign rsp_if.accel_y   = data_ff.accel_y;
   assign rsp_if.accel_z   = data_ff.accel_z;
   assign rsp_if.gyro_x    = data_ff.gyro_x;
   assign rsp_if.gyro_y    = data_ff.gyro_y;
   assign rsp_if.gyro_z    = data_ff.gyro_z;
   assign rsp_if.supply_mv = data_ff.supply_mv;

endmodule

`default_nettype wire

### test/testbench.sv
// -----------------------------------------------------------------------------
// Sensor frame receiver testbench
// Streams byte sequences through the receiver: header hunting, good frames,
// bad checksums, bad tails and cut-off frames. Random gaps and stalls are
// used on both sides. An in-bench frame parser predicts the results, and
// each result is checked field by field. Header and tail values change
// between phases, including while a frame is half received.
// -----------------------------------------------------------------------------
module testbench;

   typedef enum int {FRAME_GOOD, FRAME_BAD_SUM, FRAME_BAD_TAIL, FRAME_CUT} frame_kind_type;

   localparam logic [sfr_pkg::CSR_INDEX_W-1:0] CSR_INDEX_TOP = '1;
   localparam logic [sfr_pkg::CSR_INDEX_W-1:0] CSR_INDEX_SPARE =
      sfr_pkg::CSR_INDEX_W'(2);
   localparam int PHASE_BYTES = 340;
   localparam int DRAIN_CYCLES = 8;

   logic clock;
   logic reset;

   sfr_req_if req_if ();
   sfr_rsp_if rsp_if ();
   sfr_csr_if csr_if ();

   sensor_frame_receiver_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // parser model state and register copies
   logic [7:0] hunt_header;
   logic [7:0] tail_byte;
   int         held_count;
   logic [7:0] held_bytes [sfr_pkg::FRAME_BYTES];
   logic [7:0] held_parity;

   logic [7:0]              pending_bytes [$];
   sfr_pkg::sfr_result_type expected_frames [$];

   int error_count;
   int gap_left;
   int stall_left;
   bit req_burst;
   bit rsp_burst;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic report_error(string msg);
      error_count++;
      if (error_count <= 100)
         $display("mismatch at %0t: %s", $time, msg);
   endtask

   function automatic int draw_wait(bit burst);
      return burst ? 0 : $urandom_range(0, 6);
   endfunction

   function automatic void frame_step(logic [7:0] b);
      sfr_pkg::sfr_result_type r;
      if (held_count == 0) begin
         if (b == hunt_header) begin
            held_bytes[0] = b;
            held_parity = b;
            held_count = 1;
         end
         return;
      end
      held_bytes[held_count] = b;
      if (held_count < sfr_pkg::CHECK_POS)
         held_parity ^= b;
      held_count++;
      if (held_count < sfr_pkg::FRAME_BYTES)
         return;
      held_count = 0;
      if (held_bytes[sfr_pkg::FRAME_BYTES-1] != tail_byte ||
          held_parity != held_bytes[sfr_pkg::CHECK_POS])
         return;
      r.stop_flag = held_bytes[1];
      r.vel_x     = {held_bytes[2],  held_bytes[3]};
      r.vel_y     = {held_bytes[4],  held_bytes[5]};
      r.yaw_rate  = {held_bytes[6],  held_bytes[7]};
      r.accel_x   = {held_bytes[8],  held_bytes[9]};
      r.accel_y   = {held_bytes[10], held_bytes[11]};
      r.accel_z   = {held_bytes[12], held_bytes[13]};
      r.gyro_x    = {held_bytes[14], held_bytes[15]};
      r.gyro_y    = {held_bytes[16], held_bytes[17]};
      r.gyro_z    = {held_bytes[18], held_bytes[19]};
      r.supply_mv = {held_bytes[20], held_bytes[21]};
      expected_frames.push_back(r);
   endfunction

   task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
         report_error($sformatf("%s got %h expected %h", name, got, want));
   endtask

   task automatic check_result();
      sfr_pkg::sfr_result_type want;
      if (expected_frames.size() == 0) begin
         report_error("result with no frame pending");
         return;
      end
      want = expected_frames.pop_front();
      check_field("stop_flag", {8'h00, rsp_if.stop_flag}, {8'h00, want.stop_flag});
      check_field("vel_x",     rsp_if.vel_x,     want.vel_x);
      check_field("vel_y",     rsp_if.vel_y,     want.vel_y);
      check_field("yaw_rate",  rsp_if.yaw_rate,  want.yaw_rate);
      check_field("accel_x",   rsp_if.accel_x,   want.accel_x);
      check_field("accel_y",   rsp_if.accel_y,   want.accel_y);
      check_field("accel_z",   rsp_if.accel_z,   want.accel_z);
      check_field("gyro_x",    rsp_if.gyro_x,    want.gyro_x);
      check_field("gyro_y",    rsp_if.gyro_y,    want.gyro_y);
      check_field("gyro_z",    rsp_if.gyro_z,    want.gyro_z);
      check_field("supply_mv", rsp_if.supply_mv, want.supply_mv);
   endtask

   // byte request driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         gap_left <= 0;
      end else begin
         if (req_if.valid && req_if.ready)
            frame_step(req_if.rx_byte);
         if (!req_if.valid || req_if.ready) begin
            if (gap_left > 0) begin
               req_if.valid <= 1'b0;
               gap_left <= gap_left - 1;
            end else if (pending_bytes.size() != 0) begin
               req_if.valid <= 1'b1;
               req_if.rx_byte <= pending_bytes.pop_front();
               gap_left <= draw_wait(req_burst);
               if ($urandom_range(0, 49) == 0)
                  req_burst <= !req_burst;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor with random back-pressure
   always @(posedge clock) begin : result_monitor
      int n;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left <= 0;
      end else begin
         n = stall_left;
         if (rsp_if.valid && rsp_if.ready) begin
            check_result();
            n = draw_wait(rsp_burst);
            if ($urandom_range(0, 49) == 0)
               rsp_burst <= !rsp_burst;
         end
         if (n > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left <= n - 1;
         end else begin
            rsp_if.ready <= 1'b1;
            stall_left <= 0;
         end
      end
   end

   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         4: return {hunt_header, hunt_header};   // header value as payload
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] pick_stop();
      case ($urandom_range(0, 5))
         0: return 8'h00;
         1: return 8'hFF;
         2: return hunt_header;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic void push_frame(logic [7:0] stop, logic [9:0][15:0] words,
                                      frame_kind_type kind);
      logic [7:0] f [sfr_pkg::FRAME_BYTES];
      logic [7:0] sum;
      int len;
      f[0] = hunt_header;
      f[1] = stop;
      for (int k = 0; k < 10; k++) begin
         f[2 + 2*k] = words[k][15:8];
         f[3 + 2*k] = words[k][7:0];
      end
      sum = 8'h00;
      for (int i = 0; i < sfr_pkg::CHECK_POS; i++)
         sum ^= f[i];
      f[sfr_pkg::CHECK_POS] = sum;
      f[sfr_pkg::FRAME_BYTES-1] = tail_byte;
      len = sfr_pkg::FRAME_BYTES;
      case (kind)
         FRAME_BAD_SUM:  f[sfr_pkg::CHECK_POS] ^= 8'(1 << $urandom_range(0, 7));
         FRAME_BAD_TAIL: f[sfr_pkg::FRAME_BYTES-1] ^= 8'($urandom_range(1, 255));
         FRAME_CUT:      len = $urandom_range(1, sfr_pkg::FRAME_BYTES - 1);
         default: ;
      endcase
      for (int i = 0; i < len; i++)
         pending_bytes.push_back(f[i]);
   endfunction

   function automatic void push_random_frame(frame_kind_type kind);
      logic [9:0][15:0] words;
      for (int k = 0; k < 10; k++)
         words[k] = pick_word();
      push_frame(pick_stop(), words, kind);
   endfunction

   function automatic void fill_phase(int budget);
      int r;
      while (pending_bytes.size() < budget) begin
         repeat ($urandom_range(0, 3))
            pending_bytes.push_back(8'($urandom));
         r = $urandom_range(0, 99);
         if (r < 65)
            push_random_frame(FRAME_GOOD);
         else if (r < 77)
            push_random_frame(FRAME_BAD_SUM);
         else if (r < 89)
            push_random_frame(FRAME_BAD_TAIL);
         else
            push_random_frame(FRAME_CUT);
      end
      // often leave a frame half received across the next register writes
      if ($urandom_range(0, 1))
         push_random_frame(FRAME_CUT);
   endfunction

   task automatic csr_write(logic [sfr_pkg::CSR_INDEX_W-1:0] idx, logic [7:0] value);
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data <= value;
      do
         @(posedge clock);
      while (csr_if.ready !== 1'b1);
      if (idx == sfr_pkg::CSR_HEADER_VALUE)
         hunt_header = value;
      else if (idx == sfr_pkg::CSR_TAIL_VALUE)
         tail_byte = value;
      csr_if.valid <= 1'b0;
   endtask

   task automatic wait_quiet();
      int guard;
      guard = 0;
      while ((pending_bytes.size() != 0 || req_if.valid === 1'b1 ||
              expected_frames.size() != 0) && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [7:0] v;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.rx_byte = 8'h00;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = sfr_pkg::CSR_HEADER_VALUE;
      csr_if.data = 8'h00;
      hunt_header = sfr_pkg::HEADER_RESET;
      tail_byte = sfr_pkg::TAIL_RESET;
      held_count = 0;
      held_parity = 8'h00;
      error_count = 0;
      req_burst = 1'b0;
      rsp_burst = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: ignored noise, then a good frame of extreme values with
      // header-valued payload bytes
      pending_bytes.push_back(8'h00);
      pending_bytes.push_back(8'hFF);
      push_frame(8'hFF, {16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000, {hunt_header, hunt_header},
                         16'h0001, 16'h5AA5, 16'hA55A, 16'h00FF, 16'hFF00}, FRAME_GOOD);
      fill_phase(PHASE_BYTES);

      for (int phase = 1; phase <= 5; phase++) begin
         wait_quiet();
         case (phase)
            1: begin
               csr_write(sfr_pkg::CSR_HEADER_VALUE, 8'h00);
               csr_write(sfr_pkg::CSR_TAIL_VALUE, 8'hFF);
               csr_write(CSR_INDEX_SPARE, 8'($urandom));
            end
            2: begin
               csr_write(sfr_pkg::CSR_HEADER_VALUE, 8'hFF);
               csr_write(sfr_pkg::CSR_TAIL_VALUE, 8'h00);
            end
            3: begin
               v = 8'($urandom);
               csr_write(sfr_pkg::CSR_TAIL_VALUE, v);
               csr_write(sfr_pkg::CSR_HEADER_VALUE, v);
            end
            4: begin
               csr_write(sfr_pkg::CSR_HEADER_VALUE, 8'($urandom));
               csr_write(sfr_pkg::CSR_TAIL_VALUE, 8'($urandom));
               csr_write(CSR_INDEX_TOP, 8'($urandom));
            end
            default: begin
               csr_write(sfr_pkg::CSR_HEADER_VALUE, sfr_pkg::HEADER_RESET);
               csr_write(sfr_pkg::CSR_TAIL_VALUE, sfr_pkg::TAIL_RESET);
            end
         endcase
         fill_phase(PHASE_BYTES);
      end

      wait_quiet();
      if (expected_frames.size() != 0)
         report_error($sformatf("%0d frame results never arrived", expected_frames.size()));
      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
